### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and reset by rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked at every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/pca_pkg.sv
// ---------------------------------------------------------------------------
// pca_pkg
// Types and constants shared by the PID regulator and its serial units.
// ---------------------------------------------------------------------------
package pca_pkg;

    // Serial multiplier: unsigned A times unsigned B.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Serial divider: unsigned dividend over unsigned divisor.
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 32;

    // Configuration register indexes.
    localparam logic [3:0] REG_KP        = 4'd0;
    localparam logic [3:0] REG_KI        = 4'd1;
    localparam logic [3:0] REG_KD        = 4'd2;
    localparam logic [3:0] REG_OUT_MIN   = 4'd3;
    localparam logic [3:0] REG_OUT_MAX   = 4'd4;
    localparam logic [3:0] REG_INTEG_MIN = 4'd5;
    localparam logic [3:0] REG_INTEG_MAX = 4'd6;
    localparam logic [3:0] REG_MODE      = 4'd7;

    // Mode flag bit positions.
    localparam int MODE_ENABLE  = 0;
    localparam int MODE_REVERSE = 1;
    localparam int MODE_ABS     = 2;
    localparam int MODE_SIGNCLR = 3;

    localparam logic [3:0] MODE_RESET = 4'd9;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_INC_MUL,
        ST_INC_MUL_W,
        ST_INC_DIV,
        ST_INC_DIV_W,
        ST_DIF,
        ST_DIF_MUL_W,
        ST_DIF_DIV,
        ST_DIF_DIV_W,
        ST_P_MUL,
        ST_P_MUL_W,
        ST_I_MUL,
        ST_I_MUL_W,
        ST_D_MUL,
        ST_D_MUL_W,
        ST_FIN,
        ST_DONE
    } pca_state_t;

endpackage

### rtl/pid_controller_antiwindup.sv
// ---------------------------------------------------------------------------
// pid_controller_antiwindup
// Sampled Q16.16 PID regulator with integral clamp anti-windup.
// ---------------------------------------------------------------------------
// Usage: items arrive on the input channel (in_valid/in_ready) and every
// transfer yields exactly one result on the output channel
// (out_valid/out_ready). A sample item carries measurement, target and a
// millisecond timestamp; a clear item zeroes the integral sum.
// Gains, limits and mode flags are written through the configuration
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data), which is always ready;
// writes to indexes beyond the register list are dropped.
// A clear item, a disabled block or a sample that arrives before the interval
// has elapsed goes straight to the output register. A full update runs up to
// five products on the bit-serial multiplier and up to two quotients on the
// bit-serial divider, one after another; the integral step is skipped at an
// output limit, the derivative step when no time has elapsed. The next item
// is taken only once the result has entered the output register.
// Reset clears the loop state (time, previous error, integral, output) and
// loads the register defaults. When the receiver stalls, the finished result
// waits in the output register and the next item is still taken; its own
// result waits until the output register is free.
// ---------------------------------------------------------------------------
module pid_controller_antiwindup
    import pca_pkg::*;
#(
    parameter int unsigned INTERVAL_MS = 200
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic signed [31:0] measurement,
    input  logic signed [31:0] target,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] control_output,
    output logic               computed
);

    localparam logic [31:0] INTERVAL_W = 32'(INTERVAL_MS);
    localparam logic [31:0] MS_PER_S   = 32'd1000;
    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = S32_MAX[31:0];
        else if (v < S32_MIN)
            r = S32_MIN[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    // Upper limit is tested first, so crossed limits resolve as documented.
    function automatic logic signed [31:0] clamp(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
        logic signed [31:0] r;
        if (v > hi)
            r = hi;
        else if (v < lo)
            r = lo;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] r;
        r = v[31] ? 32'(-v) : 32'(v);
        return r;
    endfunction

    // Configuration registers.
    logic signed [31:0] kp_reg, ki_reg, kd_reg;
    logic signed [31:0] out_min_reg, out_max_reg, integ_min_reg, integ_max_reg;
    logic [3:0]         mode_reg;

    // Loop state.
    logic [31:0]        last_time_reg;
    logic signed [31:0] prev_err_reg;
    logic signed [31:0] integ_reg;
    logic signed [31:0] cv_reg;

    // Working registers for one update.
    logic signed [31:0] err_reg;
    logic [31:0]        elapsed_reg;
    logic signed [31:0] deriv_reg;
    logic signed [31:0] acc_reg;
    logic               comp_reg;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_value_reg;
    logic               out_comp_reg;

    pca_state_t state_reg, state_next;

    // Serial unit connections.
    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic               div_start, div_done;
    logic [DIV_N_W-1:0] div_n;
    logic [DIV_D_W-1:0] div_d;
    logic [DIV_N_W-1:0] div_q;

    // Input side arithmetic, used in the transfer cycle.
    logic signed [32:0] diff_in;
    logic signed [31:0] err_fwd, err_in;
    logic [31:0]        elapsed_in;
    logic               accept, update;

    // Update arithmetic.
    logic signed [32:0] err_diff;
    logic [32:0]        err_diff_mag;
    logic               same_sign, at_limit;
    logic signed [65:0] inc_val, deriv_val;
    logic               term_neg;
    logic signed [65:0] term_full;
    logic signed [31:0] term;
    logic signed [31:0] integ_new, acc_sum, total_cv;

    assign accept     = in_valid && in_ready;
    assign diff_in    = 33'(target) - 33'(measurement);
    assign err_fwd    = sat32(66'(diff_in));
    assign err_in     = mode_reg[MODE_REVERSE] ? sat32(-66'(err_fwd)) : err_fwd;
    assign elapsed_in = now_ms - last_time_reg;
    assign update     = !kind && mode_reg[MODE_ENABLE] && (elapsed_in >= INTERVAL_W);

    assign err_diff     = 33'(err_reg) - 33'(prev_err_reg);
    assign err_diff_mag = err_diff[32] ? 33'(-err_diff) : 33'(err_diff);

    assign same_sign = ((err_reg > 0) && (prev_err_reg > 0))
                    || ((err_reg < 0) && (prev_err_reg < 0));
    assign at_limit  = ((cv_reg >= out_max_reg) && (err_reg > 0))
                    || ((cv_reg <= out_min_reg) && (err_reg < 0));

    // Quotients are magnitudes; the sign comes back here.
    assign inc_val   = err_reg[31] ? -66'(div_q) : 66'(div_q);
    assign deriv_val = err_diff[32] ? -66'(div_q) : 66'(div_q);
    assign integ_new = clamp(sat32(66'(integ_reg) + inc_val), integ_min_reg, integ_max_reg);

    // Gain product: signed magnitude back to two's complement, floor shift.
    assign term_full = term_neg ? -66'(mul_p[63:0]) : 66'(mul_p[63:0]);
    assign term      = sat32(term_full >>> 16);
    assign acc_sum   = sat32(66'(acc_reg) + 66'(term));
    assign total_cv  = clamp(mode_reg[MODE_ABS] ? acc_reg
                                                : sat32(66'(cv_reg) + 66'(acc_reg)),
                             out_min_reg, out_max_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (accept) state_next = update ? ST_PREP : ST_DONE;
            ST_PREP:      state_next = at_limit ? ST_DIF : ST_INC_MUL;
            ST_INC_MUL:   state_next = ST_INC_MUL_W;
            ST_INC_MUL_W: if (mul_done) state_next = ST_INC_DIV;
            ST_INC_DIV:   state_next = ST_INC_DIV_W;
            ST_INC_DIV_W: if (div_done) state_next = ST_DIF;
            ST_DIF:       state_next = (elapsed_reg == '0) ? ST_P_MUL : ST_DIF_MUL_W;
            ST_DIF_MUL_W: if (mul_done) state_next = ST_DIF_DIV;
            ST_DIF_DIV:   state_next = ST_DIF_DIV_W;
            ST_DIF_DIV_W: if (div_done) state_next = ST_P_MUL;
            ST_P_MUL:     state_next = ST_P_MUL_W;
            ST_P_MUL_W:   if (mul_done) state_next = ST_I_MUL;
            ST_I_MUL:     state_next = ST_I_MUL_W;
            ST_I_MUL_W:   if (mul_done) state_next = ST_D_MUL;
            ST_D_MUL:     state_next = ST_D_MUL_W;
            ST_D_MUL_W:   if (mul_done) state_next = ST_FIN;
            ST_FIN:       state_next = ST_DONE;
            ST_DONE:      if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshake, unit launches and operand selection.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_n     = mul_p[DIV_N_W-1:0];
        div_d     = MS_PER_S;
        term_neg  = 1'b0;
        unique case (state_reg)
            ST_INC_MUL:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(mag32(err_reg));
                mul_b     = elapsed_reg;
            end
            ST_INC_DIV:
                div_start = 1'b1;
            ST_DIF:
            begin
                mul_start = (elapsed_reg != '0);
                mul_a     = err_diff_mag;
                mul_b     = MS_PER_S;
            end
            ST_DIF_DIV:
            begin
                div_start = 1'b1;
                div_d     = elapsed_reg;
            end
            ST_P_MUL:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(mag32(kp_reg));
                mul_b     = mag32(err_reg);
            end
            ST_I_MUL:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(mag32(ki_reg));
                mul_b     = mag32(integ_reg);
            end
            ST_D_MUL:
            begin
                mul_start = 1'b1;
                mul_a     = MUL_A_W'(mag32(kd_reg));
                mul_b     = mag32(deriv_reg);
            end
            ST_P_MUL_W: term_neg = kp_reg[31] ^ err_reg[31];
            ST_I_MUL_W: term_neg = ki_reg[31] ^ integ_reg[31];
            ST_D_MUL_W: term_neg = kd_reg[31] ^ deriv_reg[31];
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((state_reg == ST_DONE) && (!out_valid_reg || out_ready))
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    pca_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    pca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // Configuration registers. Writes must come only while the block is idle; the block does not enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            out_min_reg   <= S32_MIN[31:0];
            out_max_reg   <= S32_MAX[31:0];
            integ_min_reg <= S32_MIN[31:0];
            integ_max_reg <= S32_MAX[31:0];
            mode_reg      <= MODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KP:        kp_reg        <= cfg_data;
                REG_KI:        ki_reg        <= cfg_data;
                REG_KD:        kd_reg        <= cfg_data;
                REG_OUT_MIN:   out_min_reg   <= cfg_data;
                REG_OUT_MAX:   out_max_reg   <= cfg_data;
                REG_INTEG_MIN: integ_min_reg <= cfg_data;
                REG_INTEG_MAX: integ_max_reg <= cfg_data;
                REG_MODE:      mode_reg      <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer, loop state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_time_reg <= '0;
            prev_err_reg  <= '0;
            integ_reg     <= '0;
            cv_reg        <= '0;
            comp_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        comp_reg <= update;
                        if (kind)
                            integ_reg <= '0;
                        if (update)
                            last_time_reg <= now_ms;
                    end
                ST_PREP:
                    if (mode_reg[MODE_SIGNCLR] && !same_sign)
                        integ_reg <= '0;
                ST_INC_DIV_W:
                    if (div_done)
                        integ_reg <= integ_new;
                ST_FIN:
                begin
                    cv_reg       <= total_cv;
                    prev_err_reg <= err_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working and payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg     <= err_in;
            elapsed_reg <= elapsed_in;
        end
        if (state_reg == ST_DIF)
            deriv_reg <= '0;
        if ((state_reg == ST_DIF_DIV_W) && div_done)
            deriv_reg <= sat32(deriv_val);
        if ((state_reg == ST_P_MUL_W) && mul_done)
            acc_reg <= term;
        if (((state_reg == ST_I_MUL_W) || (state_reg == ST_D_MUL_W)) && mul_done)
            acc_reg <= acc_sum;
        if ((state_reg == ST_DONE) && (!out_valid_reg || out_ready))
        begin
            out_value_reg <= cv_reg;
            out_comp_reg  <= comp_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign control_output = out_value_reg;
    assign computed       = out_comp_reg;

endmodule

### rtl/pca_mul.sv
// ---------------------------------------------------------------------------
// pca_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module pca_mul
    import pca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               done,
    output logic [MUL_P_W-1:0] product
);

    localparam int CNT_W = $clog2(MUL_B_W);

    logic [MUL_A_W-1:0] a_reg, a_next;
    logic [MUL_P_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MUL_A_W:0]   partial;

    always_comb
    begin
        a_next    = a_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        partial   = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]}
                  + (prod_reg[0] ? {1'b0, a_reg} : '0);
        if (start)
        begin
            a_next    = a;
            prod_next = {{MUL_A_W{1'b0}}, b};
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Add the multiplicand under the current bit, then shift right.
            prod_next = {partial, prod_reg[MUL_B_W-1:1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MUL_B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

### rtl/pca_div.sv
// ---------------------------------------------------------------------------
// pca_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pca_div
    import pca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] d_reg, d_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W+1:0] diff;
    logic               fits;

    always_comb
    begin
        rem_next  = rem_reg;
        d_next    = d_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_N_W-1]};
        diff      = {1'b0, trial} - {2'b00, d_reg};
        fits      = !diff[DIV_D_W+1];
        if (start)
        begin
            rem_next  = '0;
            d_next    = divisor;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits.
            rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/pca_checker.sv
// ---------------------------------------------------------------------------
// pca_checker
// Port-level checks on the PID regulator, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pca_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        kind,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] control_output,
    input logic        computed
);

    // A stalled result holds its value.
    `ASSERT_CLK(a_out_hold,
        out_valid && !out_ready |=> out_valid && $stable(control_output) && $stable(computed),
        "result changed while stalled")

    // One item at a time: a transfer closes the input channel next cycle.
    `ASSERT_CLK(a_one_item, in_valid && in_ready |=> !in_ready, "input taken twice in a row")

    // A clear item with a free output register reports through the DONE state, not computed.
    `ASSERT_CLK(a_clear_result,
        in_valid && in_ready && kind && !out_valid |=> ##1 (out_valid && !computed),
        "clear item result missing")

    // The result register only empties through a transfer.
    `ASSERT_CLK(a_out_drop, $fell(out_valid) |-> $past(out_ready), "result dropped without transfer")

endmodule

bind pid_controller_antiwindup pca_checker u_pca_checker (.*);

### tb/sv/pid_controller_antiwindup_checker.sv
// ---------------------------------------------------------------------------
// pid_controller_antiwindup_checker
// Watches the configuration, input and output channels of the PID regulator,
// keeps its own model of the loop state and compares every result transfer.
// ---------------------------------------------------------------------------
module pid_controller_antiwindup_checker
    import pca_pkg::*;
#(
    parameter int unsigned INTERVAL_MS = 200
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               kind,
    input  logic signed [31:0] measurement,
    input  logic signed [31:0] target,
    input  logic [31:0]        now_ms,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] control_output,
    input  logic               computed,
    output int                 error_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] value;
        logic               ran;
    } pid_result_t;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    longint kp, ki, kd, omin, omax, imin, imax;
    logic [3:0] mode;
    logic [31:0] last_time;
    longint prev_err, integ, ctrl;
    pid_result_t result_q[$];

    function automatic longint sat(input longint v);
        if (v > S32_MAX) return S32_MAX;
        if (v < S32_MIN) return S32_MIN;
        return v;
    endfunction

    // Gain product with floor rounding on the 16-bit shift.
    function automatic longint gain_mul(input longint g, input longint x);
        return sat((g * x) >>> 16);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic pid_result_t update_loop(input logic k, input logic signed [31:0] meas,
                                                input logic signed [31:0] tgt,
                                                input logic [31:0] now);
        pid_result_t r;
        logic [31:0] elapsed;
        longint err, deriv, total;
        r.ran = 1'b0;
        elapsed = now - last_time;
        if (k) begin
            integ = 0;
        end else if (mode[MODE_ENABLE] && elapsed >= INTERVAL_MS) begin
            last_time = now;
            err = sat(longint'(tgt) - longint'(meas));
            if (mode[MODE_REVERSE]) err = sat(-err);
            if (mode[MODE_SIGNCLR] && !((err > 0 && prev_err > 0) || (err < 0 && prev_err < 0)))
                integ = 0;
            // Anti-windup: hold the integral while the output is pinned in that direction.
            if (!((ctrl >= omax && err > 0) || (ctrl <= omin && err < 0))) begin
                integ = sat(integ + (err * longint'({32'd0, elapsed})) / 1000);
                integ = clamp(integ, imin, imax);
            end
            if (elapsed == 0) deriv = 0;
            else deriv = sat(((err - prev_err) * 1000) / longint'({32'd0, elapsed}));
            total = sat(gain_mul(kp, err) + gain_mul(ki, integ));
            total = sat(total + gain_mul(kd, deriv));
            ctrl = mode[MODE_ABS] ? total : sat(ctrl + total);
            prev_err = err;
            ctrl = clamp(ctrl, omin, omax);
            r.ran = 1'b1;
        end
        r.value = 32'(ctrl);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("pid_controller_antiwindup_checker: %0t: %s", $realtime, what);
        error_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        pid_result_t exp_r;
        if (!rst_n) begin
            kp = 0; ki = 0; kd = 0;
            omin = S32_MIN; omax = S32_MAX; imin = S32_MIN; imax = S32_MAX;
            mode = MODE_RESET;
            last_time = '0; prev_err = 0; integ = 0; ctrl = 0;
            result_q.delete();
            error_count = 0;
            pending_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KP:        kp = longint'(signed'(cfg_data));
                    REG_KI:        ki = longint'(signed'(cfg_data));
                    REG_KD:        kd = longint'(signed'(cfg_data));
                    REG_OUT_MIN:   omin = longint'(signed'(cfg_data));
                    REG_OUT_MAX:   omax = longint'(signed'(cfg_data));
                    REG_INTEG_MIN: imin = longint'(signed'(cfg_data));
                    REG_INTEG_MAX: imax = longint'(signed'(cfg_data));
                    REG_MODE:      mode = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    exp_r = result_q.pop_front();
                    if (control_output !== exp_r.value)
                        report_mismatch($sformatf("control_output %0d, expected %0d",
                                                  control_output, exp_r.value));
                    if (computed !== exp_r.ran)
                        report_mismatch($sformatf("computed %0b, expected %0b",
                                                  computed, exp_r.ran));
                end
            end
            if (in_valid && in_ready)
                result_q.push_back(update_loop(kind, measurement, target, now_ms));
            pending_count = result_q.size();
        end
    end

endmodule

### tb/sv/pid_controller_antiwindup_test.sv
// ---------------------------------------------------------------------------
// pid_controller_antiwindup_test
// Drives the PID regulator through directed and random sample sequences
// under several register settings and flow-control patterns.
// ---------------------------------------------------------------------------
module pid_controller_antiwindup_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pca_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               kind = 1'b0;
    logic signed [31:0] measurement = '0;
    logic signed [31:0] target = '0;
    logic [31:0]        now_ms = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] control_output;
    logic               computed;
    int                 error_count;
    int                 pending_count;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int unsigned send_idle = 0;
    int unsigned recv_stall = 0;
    // Running sample clock in milliseconds; wraps naturally at 2^32.
    logic [31:0] clock_ms = '0;

    always #4 clk = ~clk;

    pid_controller_antiwindup u_top (.*);

    pid_controller_antiwindup_checker u_check (.*);

    // The receiver decides readiness at every falling edge.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall);

    // A write starts at a falling edge, after the previous one was withdrawn.
    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sends one item and waits for its transfer; a falling edge and
    // the optional idle gap come first.
    task automatic send_item(input logic k, input logic [31:0] meas, input logic [31:0] tgt,
                             input logic [31:0] now);
        do @(negedge clk); while ($urandom_range(99) < send_idle);
        in_valid    <= 1'b1;
        kind        <= k;
        measurement <= meas;
        target      <= tgt;
        now_ms      <= now;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Waits for every expected result, then lets the block drain fully.
    task automatic drain();
        while (pending_count != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(200000) - 100000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly regular sample spacing around the interval, with some jumps and wraps.
    function automatic logic [31:0] next_time();
        case ($urandom_range(9))
            0: return clock_ms + $urandom_range(199);
            1: return $urandom;
            default: return clock_ms + 200 + $urandom_range(400);
        endcase
    endfunction

    task automatic random_phase(input int count, input int unsigned idle, input int unsigned stall);
        logic [31:0] meas;
        send_idle  = idle;
        recv_stall = stall;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(19) == 0) begin
                send_item(1'b1, $urandom, $urandom, $urandom);
            end else begin
                clock_ms = next_time();
                meas = ($urandom_range(3) == 0) ? rand_word() : $urandom_range(2000000) - 1000000;
                send_item(1'b0, meas, ($urandom_range(3) == 0) ? rand_word() : 32'sd65536, clock_ms);
            end
        end
        drain();
    endtask

    // One full register setting; the gains stay small most of the time so the loop is lively.
    task automatic random_config(input logic [3:0] mode);
        logic signed [31:0] a, b;
        write_reg(REG_KP, ($urandom_range(4) == 0) ? rand_word() : $urandom_range(131072) - 65536);
        write_reg(REG_KI, ($urandom_range(4) == 0) ? rand_word() : $urandom_range(131072) - 65536);
        write_reg(REG_KD, ($urandom_range(4) == 0) ? rand_word() : $urandom_range(8192) - 4096);
        a = $urandom_range(20000000) - 10000000;
        b = $urandom_range(20000000) - 10000000;
        write_reg(REG_OUT_MIN, (a < b) || ($urandom_range(5) == 0) ? a : b);
        write_reg(REG_OUT_MAX, (a < b) || ($urandom_range(5) == 0) ? b : a);
        a = $urandom_range(20000000) - 10000000;
        b = $urandom_range(20000000) - 10000000;
        write_reg(REG_INTEG_MIN, (a < b) ? a : b);
        write_reg(REG_INTEG_MAX, (a < b) ? b : a);
        write_reg(REG_MODE, {mode[3:1], 1'b1});
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at reset defaults: gains are zero, so output stays put.
        send_item(1'b0, 32'sd0, 32'sd65536, 32'd100);
        send_item(1'b0, 32'h80000000, 32'h7fffffff, 32'd200);
        drain();

        // Unit proportional and integral gain with real limits.
        write_reg(REG_KP, 32'sd65536);
        write_reg(REG_KI, 32'sd65536);
        write_reg(REG_KD, 32'sd6554);
        write_reg(REG_OUT_MIN, -32'sd655360);
        write_reg(REG_OUT_MAX, 32'sd655360);
        write_reg(REG_INTEG_MIN, -32'sd327680);
        write_reg(REG_INTEG_MAX, 32'sd327680);
        write_reg(REG_MODE, 4'b1101);
        write_reg(4'd12, 32'hffffffff);
        send_item(1'b0, 32'sd0, 32'sd65536, 32'd400);
        send_item(1'b0, 32'sd0, 32'sd65536, 32'd500);
        send_item(1'b0, 32'sd0, 32'h7fffffff, 32'd700);
        send_item(1'b0, 32'sd0, 32'h7fffffff, 32'd1700);
        send_item(1'b0, 32'sd65536, 32'sd0, 32'd1900);
        send_item(1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_item(1'b0, 32'h7fffffff, 32'h80000000, 32'hffffff00);
        send_item(1'b0, 32'sd0, 32'sd0, 32'd300);
        drain();

        // Reverse, incremental output, crossed output limits and extreme gains.
        write_reg(REG_KP, 32'h7fffffff);
        write_reg(REG_KD, 32'h80000000);
        write_reg(REG_OUT_MIN, 32'sd65536);
        write_reg(REG_OUT_MAX, -32'sd65536);
        write_reg(REG_MODE, 4'b0011);
        send_item(1'b0, 32'sd100, 32'sd0, 32'd600);
        send_item(1'b0, 32'h80000000, 32'h7fffffff, 32'd900);
        send_item(1'b0, 32'h7fffffff, 32'h80000000, 32'd1200);
        drain();
        write_reg(REG_MODE, 4'b0000);
        send_item(1'b0, 32'sd5, 32'sd9, 32'd5000);
        send_item(1'b1, 32'sd0, 32'sd0, 32'd0);
        drain();

        // Random phases over every flow-control pattern and several settings.
        for (int p = 0; p < 12; p++) begin
            random_config($urandom_range(15));
            random_phase(125, (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 33 : 49) : 0,
                         (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 33 : 49) : 0);
        end

        if (error_count == 0)
            $display("pid_controller_antiwindup_test: done, clean");
        else
            $display("pid_controller_antiwindup_test: done, errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("pid_controller_antiwindup_test: done, errors");
        $finish;
    end

endmodule
